// ===== design/gpc_pkg.sv =====
// gpc_pkg: shared types, constants and helpers of the probability coarsener
// used by gpc_div and grouped_probability_coarsener_unit
`default_nettype none

package gpc_pkg;

    localparam int PROB_BITS = 16;
    localparam int MAX_GROUP = 64;
    localparam int CNT_W     = 7;                  // holds 0..MAX_GROUP
    localparam int POS_W     = 6;                  // holds 0..MAX_GROUP-1
    localparam int SUM_W     = CNT_W + PROB_BITS;  // MAX_GROUP full-scale probabilities
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = 5;

    localparam logic [1:0] CFG_GROUP_SIZE  = 2'd0;
    localparam logic [1:0] CFG_START_PHASE = 2'd1;
    localparam logic [1:0] CFG_VOTE_MODE   = 2'd2;

    localparam logic [1:0] CLS_HELIX  = 2'd0;
    localparam logic [1:0] CLS_STRAND = 2'd1;
    localparam logic [1:0] CLS_COIL   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PHASE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ACC,
        S_POST,
        S_OUT_PREV,
        S_OUT_CUR,
        S_END
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [CNT_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quo;
        logic [CNT_W-1:0] rem;
    } t_div_rsp;

    // group size clamped to 1..MAX_GROUP
    function automatic logic [CNT_W-1:0] eff_group(input logic [CNT_W-1:0] gs);
        logic [CNT_W-1:0] g;
        g = gs;
        if (gs == '0) begin
            g = CNT_W'(1);
        end else if (gs > CNT_W'(MAX_GROUP)) begin
            g = CNT_W'(MAX_GROUP);
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== design/gpc_div.sv =====
// gpc_div: shared restoring divider, one quotient bit per cycle
// depends on gpc_pkg for widths and the request/response structs
`default_nettype none

module gpc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gpc_pkg::t_div_req i_req,
    output gpc_pkg::t_div_rsp      o_rsp
);

    logic [gpc_pkg::SUM_W-1:0]  r_quo;
    logic [gpc_pkg::CNT_W-1:0]  r_rem;
    logic [gpc_pkg::CNT_W-1:0]  r_den;
    logic [gpc_pkg::DCNT_W-1:0] r_cnt;
    logic                       r_done;

    logic [gpc_pkg::CNT_W-1:0]  w_shift;
    logic                       w_ge;
    logic [gpc_pkg::CNT_W-1:0]  w_diff;

    // remainder stays below the divisor, so its top bit is always clear
    assign w_shift = {r_rem[gpc_pkg::CNT_W-2:0], r_quo[gpc_pkg::SUM_W-1]};
    assign w_ge    = (w_shift >= r_den);
    assign w_diff  = w_shift - r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == gpc_pkg::DCNT_W'(1));
            if (i_req.start) begin
                r_cnt <= gpc_pkg::DCNT_W'(gpc_pkg::DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - gpc_pkg::DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[gpc_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff : w_shift;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

// ===== design/grouped_probability_coarsener_unit.sv =====
// grouped_probability_coarsener_unit: bins residue probabilities into coarse means or votes
// depends on gpc_pkg and gpc_div (the one divider shared by phase and bin results)
// an item without a bin result passes through the start, accumulate, post and end states
// the first residue of a sequence also waits in the phase state for the phase remainder
// each bin result adds three divisions in gpc_div, one per class, plus output handoff
// synchronous active-low reset restores group size 1, phase 0, mean mode and clears all bins
`default_nettype none

module grouped_probability_coarsener_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_helix_prob,
    input  wire logic [15:0] i_strand_prob,
    input  wire logic [15:0] i_coil_prob,
    input  wire logic        i_final_residue,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_avg_helix,
    output logic [15:0]      o_avg_strand,
    output logic [15:0]      o_avg_coil,
    output logic             o_final_bin,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);

    localparam int PB = gpc_pkg::PROB_BITS;
    localparam int CW = gpc_pkg::CNT_W;
    localparam int PW = gpc_pkg::POS_W;
    localparam int SW = gpc_pkg::SUM_W;

    gpc_pkg::t_state   r_state, n_state;

    logic [CW-1:0]     r_group_size;
    logic [PW-1:0]     r_start_phase;
    logic              r_vote_mode;

    logic [PB-1:0]     r_prob [3];
    logic              r_fin;
    logic [CW-1:0]     r_g;
    logic [SW-1:0]     r_sum [3];
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     r_pos;
    logic [CW-1:0]     r_skip;
    logic              r_started;
    logic              r_have_prev;
    logic              r_cur_emit;
    logic              r_div_cur;
    logic [1:0]        r_cls;
    logic [PB-1:0]     r_q [3];

    logic              r_out_valid;
    logic [PB-1:0]     r_out_h, r_out_s, r_out_c;
    logic              r_out_final;

    gpc_pkg::t_div_req w_req;
    gpc_pkg::t_div_rsp w_rsp;

    logic [CW-1:0]     w_eff_g;
    logic [CW-1:0]     w_pos_inc;
    logic [PW-1:0]     w_pos_next;
    logic              w_wrap_emit;
    logic [PW-1:0]     w_phase;
    logic [CW-1:0]     w_skip_init;
    logic [CW-1:0]     w_r;
    logic              w_keep;
    logic              w_cur_emit;
    logic [1:0]        w_win;
    logic [SW-1:0]     w_sum_sel;
    logic [SW-1:0]     w_num;
    logic [PB-1:0]     w_q_sat;
    logic              w_free;
    logic              w_load_out;
    logic              w_out_final;
    logic              w_accept;

    gpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_eff_g     = gpc_pkg::eff_group(r_group_size);
    assign w_pos_inc   = {1'b0, r_pos} + CW'(1);
    assign w_pos_next  = (w_pos_inc >= r_g) ? '0 : w_pos_inc[PW-1:0];
    assign w_wrap_emit = (w_pos_next == '0) && (r_count != '0);

    // phase is the remainder of start_phase by the group size
    assign w_phase     = w_rsp.rem[PW-1:0];
    assign w_skip_init = ({w_phase, 1'b0} >= r_g) ? (r_g - {1'b0, w_phase}) : '0;

    // trailing bin is kept when it is full or at least half full
    assign w_r        = (w_pos_inc == r_g) ? '0 : w_pos_inc;
    assign w_keep     = (w_r == '0) || ({w_r, 1'b0} >= {1'b0, r_g});
    assign w_cur_emit = r_fin && w_keep && (r_count != '0);

    // winner: strict greater, ties to the lower class
    always_comb begin
        logic [PB-1:0] best;
        w_win = gpc_pkg::CLS_HELIX;
        best  = r_prob[0];
        if (r_prob[1] > best) begin
            w_win = gpc_pkg::CLS_STRAND;
            best  = r_prob[1];
        end
        if (r_prob[2] > best) begin
            w_win = gpc_pkg::CLS_COIL;
        end
    end

    assign w_sum_sel = r_sum[r_cls];
    assign w_num     = r_vote_mode ? {w_sum_sel[CW-1:0], {PB{1'b0}}} : w_sum_sel;

    // a vote fraction of one or more, or a quotient beyond 16 bits, saturates
    always_comb begin
        if ((r_vote_mode && (w_sum_sel >= {{(SW-CW){1'b0}}, r_count}))
            || (|w_rsp.quo[SW-1:PB])) begin
            w_q_sat = '1;
        end else begin
            w_q_sat = w_rsp.quo[PB-1:0];
        end
    end

    assign w_free   = !r_out_valid || !i_out_stall;
    assign w_accept = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gpc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = gpc_pkg::S_START;
            end
            gpc_pkg::S_START: begin
                if (!r_started) begin
                    n_state = gpc_pkg::S_PHASE;
                end else if (w_wrap_emit) begin
                    n_state = gpc_pkg::S_DIV_GO;
                end else begin
                    n_state = gpc_pkg::S_ACC;
                end
            end
            gpc_pkg::S_PHASE: begin
                if (w_rsp.done) n_state = gpc_pkg::S_ACC;
            end
            gpc_pkg::S_DIV_GO: begin
                n_state = gpc_pkg::S_DIV_WAIT;
            end
            gpc_pkg::S_DIV_WAIT: begin
                if (w_rsp.done) begin
                    if (r_cls == gpc_pkg::CLS_COIL) begin
                        n_state = r_div_cur ? gpc_pkg::S_OUT_CUR : gpc_pkg::S_ACC;
                    end else begin
                        n_state = gpc_pkg::S_DIV_GO;
                    end
                end
            end
            gpc_pkg::S_ACC: begin
                n_state = gpc_pkg::S_POST;
            end
            gpc_pkg::S_POST: begin
                if (r_have_prev) begin
                    n_state = gpc_pkg::S_OUT_PREV;
                end else if (w_cur_emit) begin
                    n_state = gpc_pkg::S_DIV_GO;
                end else begin
                    n_state = gpc_pkg::S_END;
                end
            end
            gpc_pkg::S_OUT_PREV: begin
                if (w_free) n_state = r_cur_emit ? gpc_pkg::S_DIV_GO : gpc_pkg::S_END;
            end
            gpc_pkg::S_OUT_CUR: begin
                if (w_free) n_state = gpc_pkg::S_END;
            end
            gpc_pkg::S_END: begin
                n_state = gpc_pkg::S_IDLE;
            end
            default: n_state = gpc_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_req       = '0;
        w_load_out  = 1'b0;
        w_out_final = 1'b0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            gpc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            gpc_pkg::S_START: begin
                if (!r_started) begin
                    w_req.start = 1'b1;
                    w_req.num   = {{(SW-PW){1'b0}}, r_start_phase};
                    w_req.den   = r_g;
                end
            end
            gpc_pkg::S_DIV_GO: begin
                w_req.start = 1'b1;
                w_req.num   = w_num;
                w_req.den   = r_count;
            end
            gpc_pkg::S_OUT_PREV: begin
                w_load_out  = w_free;
                w_out_final = r_fin && !r_cur_emit;
            end
            gpc_pkg::S_OUT_CUR: begin
                w_load_out  = w_free;
                w_out_final = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control and bin state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gpc_pkg::S_IDLE;
            r_group_size  <= CW'(1);
            r_start_phase <= '0;
            r_vote_mode   <= 1'b0;
            r_sum[0]      <= '0;
            r_sum[1]      <= '0;
            r_sum[2]      <= '0;
            r_count       <= '0;
            r_pos         <= '0;
            r_skip        <= '0;
            r_started     <= 1'b0;
            r_have_prev   <= 1'b0;
            r_cur_emit    <= 1'b0;
            r_div_cur     <= 1'b0;
            r_cls         <= gpc_pkg::CLS_HELIX;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gpc_pkg::CFG_GROUP_SIZE:  r_group_size  <= i_cfg_data;
                    gpc_pkg::CFG_START_PHASE: r_start_phase <= i_cfg_data[PW-1:0];
                    gpc_pkg::CFG_VOTE_MODE:   r_vote_mode   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (w_load_out) r_out_valid <= 1'b1;

            unique case (r_state)
                gpc_pkg::S_START: begin
                    if (r_started) begin
                        r_pos <= w_pos_next;
                        if (w_wrap_emit) begin
                            r_div_cur <= 1'b0;
                            r_cls     <= gpc_pkg::CLS_HELIX;
                        end
                    end
                end
                gpc_pkg::S_PHASE: begin
                    if (w_rsp.done) begin
                        r_pos     <= w_phase;
                        r_skip    <= w_skip_init;
                        r_started <= 1'b1;
                        r_sum[0]  <= '0;
                        r_sum[1]  <= '0;
                        r_sum[2]  <= '0;
                        r_count   <= '0;
                    end
                end
                gpc_pkg::S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_cls == gpc_pkg::CLS_COIL) begin
                            if (!r_div_cur) begin
                                r_have_prev <= 1'b1;
                                r_sum[0]    <= '0;
                                r_sum[1]    <= '0;
                                r_sum[2]    <= '0;
                                r_count     <= '0;
                            end
                        end else begin
                            r_cls <= r_cls + 2'd1;
                        end
                    end
                end
                gpc_pkg::S_ACC: begin
                    if (r_skip != '0) begin
                        r_skip <= r_skip - CW'(1);
                    end else begin
                        r_count <= r_count + CW'(1);
                        for (int i = 0; i < 3; i++) begin
                            if (r_vote_mode) begin
                                if (w_win == 2'(i)) r_sum[i] <= r_sum[i] + SW'(1);
                            end else begin
                                r_sum[i] <= r_sum[i] + SW'(r_prob[i]);
                            end
                        end
                    end
                end
                gpc_pkg::S_POST: begin
                    r_cur_emit <= w_cur_emit;
                    if (!r_have_prev && w_cur_emit) begin
                        r_div_cur <= 1'b1;
                        r_cls     <= gpc_pkg::CLS_HELIX;
                    end
                end
                gpc_pkg::S_OUT_PREV: begin
                    if (w_free) begin
                        r_have_prev <= 1'b0;
                        if (r_cur_emit) begin
                            r_div_cur <= 1'b1;
                            r_cls     <= gpc_pkg::CLS_HELIX;
                        end
                    end
                end
                gpc_pkg::S_END: begin
                    r_cur_emit <= 1'b0;
                    if (r_fin) begin
                        r_sum[0]  <= '0;
                        r_sum[1]  <= '0;
                        r_sum[2]  <= '0;
                        r_count   <= '0;
                        r_pos     <= '0;
                        r_skip    <= '0;
                        r_started <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prob[0] <= i_helix_prob;
            r_prob[1] <= i_strand_prob;
            r_prob[2] <= i_coil_prob;
            r_fin     <= i_final_residue;
            r_g       <= w_eff_g;
        end
        if ((r_state == gpc_pkg::S_DIV_WAIT) && w_rsp.done) begin
            r_q[r_cls] <= w_q_sat;
        end
        if (w_load_out) begin
            r_out_h     <= r_q[0];
            r_out_s     <= r_q[1];
            r_out_c     <= r_q[2];
            r_out_final <= w_out_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_avg_helix  = r_out_h;
    assign o_avg_strand = r_out_s;
    assign o_avg_coil   = r_out_c;
    assign o_final_bin  = r_out_final;
    assign o_cfg_ready  = 1'b1;

endmodule

`default_nettype wire

// ===== bench/gpc_bin_checker.sv =====
`timescale 1ns / 1ps
// gpc_bin_checker: watches the residue, bin and register channels of the coarsener,
// predicts every coarse bin word and compares it field by field (uses gpc_pkg)

module gpc_bin_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [15:0] i_helix_prob,
    input  wire logic [15:0] i_strand_prob,
    input  wire logic [15:0] i_coil_prob,
    input  wire logic        i_final_residue,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_avg_helix,
    input  wire logic [15:0] i_avg_strand,
    input  wire logic [15:0] i_avg_coil,
    input  wire logic        i_final_bin,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [15:0] helix;
        logic [15:0] strand;
        logic [15:0] coil;
        logic        final_bin;
    } t_bin_word;

    logic [6:0]  group_size  = 7'd1;
    logic [5:0]  start_phase = 6'd0;
    logic        vote_mode   = 1'b0;

    logic [31:0] class_sums [0:2];
    logic [6:0]  bin_count  = '0;
    logic [5:0]  pos_in_bin = '0;
    logic [6:0]  skip_left  = '0;
    logic        seq_open   = 1'b0;

    t_bin_word   bins_due [$];
    t_bin_word   want;
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    initial begin
        class_sums[0] = '0;
        class_sums[1] = '0;
        class_sums[2] = '0;
    end

    task automatic clear_bin();
        class_sums[gpc_pkg::CLS_HELIX]  = '0;
        class_sums[gpc_pkg::CLS_STRAND] = '0;
        class_sums[gpc_pkg::CLS_COIL]   = '0;
        bin_count = '0;
    endtask

    // mean or vote fraction of the open bin, saturated to Q0.16
    function automatic t_bin_word bin_result(input logic fin);
        t_bin_word   w;
        logic [47:0] v;
        logic [15:0] q [0:2];
        int          k;
        for (k = 0; k < 3; k++) begin
            if (vote_mode) begin
                v = {16'd0, class_sums[k]} << gpc_pkg::PROB_BITS;
            end else begin
                v = {16'd0, class_sums[k]};
            end
            v = v / bin_count;
            if (v > 48'hFFFF) begin
                v = 48'hFFFF;
            end
            q[k] = v[15:0];
        end
        w.helix     = q[gpc_pkg::CLS_HELIX];
        w.strand    = q[gpc_pkg::CLS_STRAND];
        w.coil      = q[gpc_pkg::CLS_COIL];
        w.final_bin = fin;
        return w;
    endfunction

    task automatic coarsen_residue(input logic [15:0] helix, input logic [15:0] strand,
                                   input logic [15:0] coil, input logic fin);
        int          g;
        int          ph;
        int          pos;
        int          r;
        int          win;
        int          k;
        int          n_out;
        logic [15:0] p [0:2];
        logic [15:0] best;
        g = group_size;
        if (g < 1) begin
            g = 1;
        end
        if (g > gpc_pkg::MAX_GROUP) begin
            g = gpc_pkg::MAX_GROUP;
        end
        ph = start_phase % g;
        p[gpc_pkg::CLS_HELIX]  = helix;
        p[gpc_pkg::CLS_STRAND] = strand;
        p[gpc_pkg::CLS_COIL]   = coil;
        n_out = 0;

        if (!seq_open) begin
            seq_open  = 1'b1;
            pos       = ph;
            skip_left = (2 * ph >= g) ? 7'(g - ph) : 7'd0;
            clear_bin();
        end else begin
            pos = pos_in_bin + 1;
            if (pos >= g) begin
                pos = 0;
            end
            if (pos == 0 && bin_count > 0) begin
                bins_due = {bins_due, bin_result(1'b0)};
                n_out++;
                clear_bin();
            end
        end
        pos_in_bin = 6'(pos);

        if (skip_left > 0) begin
            skip_left--;
        end else begin
            if (vote_mode) begin
                // strict compare from zero: ties and all-zero go to the lower class
                win  = gpc_pkg::CLS_HELIX;
                best = '0;
                for (k = 0; k < 3; k++) begin
                    if (p[k] > best) begin
                        best = p[k];
                        win  = k;
                    end
                end
                class_sums[win] = class_sums[win] + 1;
            end else begin
                for (k = 0; k < 3; k++) begin
                    class_sums[k] = class_sums[k] + p[k];
                end
            end
            bin_count++;
        end

        if (fin) begin
            r = (pos + 1) % g;
            if (!(r != 0 && 2 * r < g) && bin_count > 0) begin
                bins_due = {bins_due, bin_result(1'b1)};
            end else if (n_out > 0) begin
                // trailing bin dropped: the word emitted just now closes the sequence
                bins_due[bins_due.size() - 1].final_bin = 1'b1;
            end
            clear_bin();
            pos_in_bin = '0;
            skip_left  = '0;
            seq_open   = 1'b0;
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            group_size  = 7'd1;
            start_phase = '0;
            vote_mode   = 1'b0;
            clear_bin();
            pos_in_bin  = '0;
            skip_left   = '0;
            seq_open    = 1'b0;
            bins_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    gpc_pkg::CFG_GROUP_SIZE:  group_size  = i_cfg_data;
                    gpc_pkg::CFG_START_PHASE: start_phase = i_cfg_data[5:0];
                    gpc_pkg::CFG_VOTE_MODE:   vote_mode   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                coarsen_residue(i_helix_prob, i_strand_prob, i_coil_prob, i_final_residue);
            end
            if (i_out_valid && !i_out_stall) begin
                if (bins_due.size() == 0) begin
                    $error("unexpected bin word: helix %0d strand %0d coil %0d final_bin %0d",
                           i_avg_helix, i_avg_strand, i_avg_coil, i_final_bin);
                    fail_total++;
                end else begin
                    want = bins_due.pop_front();
                    check_field("avg_helix", want.helix, i_avg_helix);
                    check_field("avg_strand", want.strand, i_avg_strand);
                    check_field("avg_coil", want.coil, i_avg_coil);
                    check_field("final_bin", 16'(want.final_bin), 16'(i_final_bin));
                end
            end
        end
        o_pending <= bins_due.size();
    end

endmodule

// ===== bench/grouped_probability_coarsener_unit_test.sv =====
`timescale 1ns / 1ps
// grouped_probability_coarsener_unit_test: drives residues and register writes into the
// coarsener with random idling; gpc_bin_checker (and gpc_pkg) does prediction and compare

module grouped_probability_coarsener_unit_test;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [15:0] i_helix_prob    = '0;
    logic [15:0] i_strand_prob   = '0;
    logic [15:0] i_coil_prob     = '0;
    logic        i_final_residue = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [6:0]  i_cfg_data      = '0;

    wire logic        o_in_stall;
    wire logic        o_out_valid;
    wire logic [15:0] o_avg_helix;
    wire logic [15:0] o_avg_strand;
    wire logic [15:0] o_avg_coil;
    wire logic        o_final_bin;
    wire logic        o_cfg_ready;

    int fail_count;
    int bins_pending;
    int residues_sent = 0;
    int stall_left    = 0;
    int calm_left     = 0;
    bit idle_off      = 1'b0;
    bit gaps_on       = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    grouped_probability_coarsener_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_helix_prob    (i_helix_prob),
        .i_strand_prob   (i_strand_prob),
        .i_coil_prob     (i_coil_prob),
        .i_final_residue (i_final_residue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_avg_helix     (o_avg_helix),
        .o_avg_strand    (o_avg_strand),
        .o_avg_coil      (o_avg_coil),
        .o_final_bin     (o_final_bin),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    gpc_bin_checker u_bin_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_helix_prob    (i_helix_prob),
        .i_strand_prob   (i_strand_prob),
        .i_coil_prob     (i_coil_prob),
        .i_final_residue (i_final_residue),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_avg_helix     (o_avg_helix),
        .i_avg_strand    (o_avg_strand),
        .i_avg_coil      (o_avg_coil),
        .i_final_bin     (o_final_bin),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (bins_pending)
    );

    // receiver backpressure: random stall bursts with calm stretches between
    always @(posedge i_clk) begin
        if (idle_off || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (calm_left > 0) begin
            i_out_stall <= 1'b0;
            calm_left   <= calm_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 6);
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 49) == 0) begin
                calm_left <= $urandom_range(50, 300);
            end
        end
    end

    // leaves valid high so that back-to-back writes need no drop in between
    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] gs, input logic [6:0] ph, input logic [6:0] vm);
        write_reg(gpc_pkg::CFG_GROUP_SIZE, gs);
        write_reg(gpc_pkg::CFG_START_PHASE, ph);
        write_reg(gpc_pkg::CFG_VOTE_MODE, vm);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_residue(input logic [15:0] helix, input logic [15:0] strand,
                                input logic [15:0] coil, input logic fin);
        int gap;
        if (!idle_off && gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_helix_prob    <= helix;
        i_strand_prob   <= strand;
        i_coil_prob     <= coil;
        i_final_residue <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        residues_sent++;
    endtask

    // wait for every pending bin word, then let a residue with no result finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bins_pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_prob();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random_residue(input logic fin);
        logic [15:0] helix;
        logic [15:0] strand;
        logic [15:0] coil;
        helix  = rand_prob();
        strand = ($urandom_range(0, 5) == 0) ? helix : rand_prob();
        coil   = ($urandom_range(0, 5) == 0) ? strand : rand_prob();
        send_residue(helix, strand, coil, fin);
    endtask

    // random register setting, mostly small groups; returns the clamped group size
    task automatic random_config(output int ge);
        logic [6:0] gs;
        logic [6:0] ph;
        case ($urandom_range(0, 19))
            0:       gs = 7'd0;
            1:       gs = 7'd64;
            2:       gs = 7'($urandom_range(65, 127));
            3, 4:    gs = 7'($urandom_range(9, 32));
            default: gs = 7'($urandom_range(1, 8));
        endcase
        ge = (gs == 0) ? 1 : ((gs > gpc_pkg::MAX_GROUP) ? gpc_pkg::MAX_GROUP : gs);
        if ($urandom_range(0, 1) == 0) begin
            ph = 7'($urandom_range(0, ge - 1)) | 7'($urandom_range(0, 1) << 6);
        end else begin
            ph = 7'($urandom_range(0, 127));
        end
        configure(gs, ph, 7'($urandom_range(0, 127)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    end

    initial begin
        int ge;
        int nseq;
        int sq;
        int len;
        int k;
        bit leave_open;

        @(posedge i_rst_n);
        @(posedge i_clk);

        // reset setting: one residue per bin
        send_residue(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_residue(16'd0, 16'd0, 16'd0, 1'b1);
        settle();

        // phase past half a bin skips the leading partial bin, short tail is dropped
        configure(7'd4, 7'd3, 7'd0);
        send_residue(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_residue(16'd0, 16'hFFFF, 16'd0, 1'b0);
        send_residue(16'd0, 16'd0, 16'hFFFF, 1'b0);
        send_residue(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_residue(16'd1, 16'd2, 16'd3, 1'b0);
        send_residue(16'd7, 16'd7, 16'd7, 1'b1);
        settle();

        // vote mode with ties, phase written with its unused top bit set
        configure(7'd3, 7'd65, 7'd1);
        send_residue(16'd0, 16'd0, 16'd0, 1'b0);
        send_residue(16'd5, 16'd5, 16'd1, 1'b0);
        send_residue(16'd1, 16'd7, 16'd7, 1'b0);
        send_residue(16'd1, 16'd2, 16'd9, 1'b0);
        send_residue(16'hFFFF, 16'hFFFF, 16'd0, 1'b1);
        settle();

        // group size zero acts as one: every bin is a full vote
        configure(7'd0, 7'd0, 7'd1);
        send_residue(16'd9, 16'd3, 16'd3, 1'b0);
        send_residue(16'd0, 16'd0, 16'd0, 1'b1);
        settle();

        // oversize group clamps, top phase skips the only residue: no word at all
        configure(7'd127, 7'd63, 7'd0);
        send_residue(16'hFFFF, 16'h8000, 16'h0001, 1'b1);
        settle();

        // lone residue in a short trailing bin is dropped
        configure(7'd4, 7'd0, 7'd0);
        send_residue(16'h1234, 16'h5678, 16'h9ABC, 1'b1);
        settle();

        // registers change while a sequence is open
        configure(7'd8, 7'd0, 7'd0);
        for (k = 0; k < 5; k++) begin
            send_random_residue(1'b0);
        end
        settle();
        write_reg(gpc_pkg::CFG_GROUP_SIZE, 7'd3);
        write_reg(gpc_pkg::CFG_VOTE_MODE, 7'd1);
        write_reg(CFG_UNUSED, 7'd127);
        i_cfg_valid <= 1'b0;
        send_random_residue(1'b0);
        send_random_residue(1'b0);
        send_random_residue(1'b1);
        settle();

        while (residues_sent < 1400) begin
            random_config(ge);
            nseq = (ge > 16) ? 2 : $urandom_range(2, 6);
            for (sq = 0; sq < nseq; sq++) begin
                gaps_on    = ($urandom_range(0, 9) < 7);
                len        = $urandom_range(1, 3 * ge + 2);
                // keep the random part from running far past its share
                if (residues_sent + len > 1450) begin
                    len = (residues_sent < 1449) ? (1450 - residues_sent) : 1;
                end
                leave_open = (sq == nseq - 1) && ($urandom_range(0, 7) == 0);
                for (k = 0; k < len; k++) begin
                    send_random_residue((k == len - 1) && !leave_open);
                end
            end
            settle();
        end

        // closing stretch at full rate on both sides
        idle_off = 1'b1;
        do begin
            configure(7'($urandom_range(1, 6)), 7'($urandom_range(0, 5)),
                      7'($urandom_range(0, 1)));
            for (sq = 0; sq < 4; sq++) begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    send_random_residue(k == len - 1);
                end
            end
            settle();
        end while (residues_sent < 1550);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (bins_pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && bins_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/gpc_pkg.sv
design/gpc_div.sv
design/grouped_probability_coarsener_unit.sv
bench/gpc_bin_checker.sv
bench/grouped_probability_coarsener_unit_test.sv
